FILE: src/gcne_pkg.sv
// Shared constants, types and register indexes of the grid cell neighbor enumerator.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps

package gcne_pkg;

  localparam int AXIS_BITS  = 8;
  localparam int COORD_BITS = 24;

  localparam int SIZE_W     = 23;
  localparam int COUNT_W    = AXIS_BITS + 1;
  localparam int DIV_W      = COORD_BITS - 1;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int CMP_W      = (DIV_W > COUNT_W) ? DIV_W : COUNT_W;
  localparam int NXNY_W     = 2 * AXIS_BITS + 1;
  localparam int IDX_W      = 3 * AXIS_BITS;
  localparam int ORD_W      = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (SIZE_W > COUNT_W) ? SIZE_W : COUNT_W;

  localparam int IN_RAW_W   = 3 * COORD_BITS;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = IDX_W + 3 * AXIS_BITS + ORD_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] AXIS_MAX = COUNT_W'(1) << AXIS_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X  = CFG_IDX_W'(0),
    REG_SIZE_Y  = CFG_IDX_W'(1),
    REG_SIZE_Z  = CFG_IDX_W'(2),
    REG_CELLS_X = CFG_IDX_W'(3),
    REG_CELLS_Y = CFG_IDX_W'(4),
    REG_CELLS_Z = CFG_IDX_W'(5)
  } cfg_reg_e;

  typedef struct packed {
    logic [SIZE_W-1:0]  size_x;
    logic [SIZE_W-1:0]  size_y;
    logic [SIZE_W-1:0]  size_z;
    logic [COUNT_W-1:0] cnt_x;
    logic [COUNT_W-1:0] cnt_y;
    logic [COUNT_W-1:0] cnt_z;
  } cfg_t;

  typedef struct packed {
    logic                 outside;
    logic [AXIS_BITS-1:0] cx;
    logic [AXIS_BITS-1:0] cy;
    logic [AXIS_BITS-1:0] cz;
  } cell_t;

endpackage

FILE: src/grid_cell_neighbor_enumerator.sv
// Top level of the grid cell neighbor enumerator: configuration registers, front end,
// cell queue and back end. Depends on gcne_pkg, gcne_front, gcne_queue, gcne_back.
//
//   channel   direction  handshake                        payload
//   s_axis    in         s_axis_tvalid / s_axis_tready    tdata: pos_x, pos_y, pos_z
//   m_axis    out        m_axis_tvalid / m_axis_tready    tdata: cell_index, cell_x, cell_y,
//                                                         cell_z, ordinal; tuser; tlast
//   cfg       in         cfg_we_i                         cfg_idx_i, cfg_data_i
//
// The front end loads a request, runs COORD_BITS - 1 divider steps and pushes the cell;
// only then does it start the next request, which is held in an input register meanwhile.
// The back end emits one result per cycle unless the output stalls: 27 for a cell in the
// middle of the grid, 8 in a corner, down to 1 on a single-cell grid and 1 for an outside
// position. Between the queue and the output port lie the walk registers, the product stage
// and the output register. Reset clears all control state and sets every configuration
// register to 1; stalls on the output port propagate back via the queue to s_axis_tready.
`timescale 1ns / 1ps

module grid_cell_neighbor_enumerator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x [23:0], pos_y [47:24], pos_z [71:48]
  input  logic [gcne_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cell_index [23:0], cell_x [31:24], cell_y [39:32], cell_z [47:40], ordinal [52:48]
  output logic [gcne_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // outside [0]
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we_i,
  input  logic [gcne_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gcne_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import gcne_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic [NXNY_W-1:0] nxny_q;
  logic [SIZE_W-1:0] wr_size;
  logic [COUNT_W-1:0] wr_cnt_raw, wr_cnt;

  logic  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  cell_t q_push_data, q_pop_data;

  always_comb begin
    wr_size    = (cfg_data_i[SIZE_W-1:0] == '0) ? SIZE_W'(1) : cfg_data_i[SIZE_W-1:0];
    wr_cnt_raw = cfg_data_i[COUNT_W-1:0];
    wr_cnt     = (wr_cnt_raw > AXIS_MAX) ? AXIS_MAX : wr_cnt_raw;
    cfg_d      = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIZE_X:  cfg_d.size_x = wr_size;
        REG_SIZE_Y:  cfg_d.size_y = wr_size;
        REG_SIZE_Z:  cfg_d.size_z = wr_size;
        REG_CELLS_X: cfg_d.cnt_x  = wr_cnt;
        REG_CELLS_Y: cfg_d.cnt_y  = wr_cnt;
        REG_CELLS_Z: cfg_d.cnt_z  = wr_cnt;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x <= SIZE_W'(1);
      cfg_q.size_y <= SIZE_W'(1);
      cfg_q.size_z <= SIZE_W'(1);
      cfg_q.cnt_x  <= COUNT_W'(1);
      cfg_q.cnt_y  <= COUNT_W'(1);
      cfg_q.cnt_z  <= COUNT_W'(1);
      nxny_q       <= NXNY_W'(1);
    end else begin
      cfg_q  <= cfg_d;
      nxny_q <= NXNY_W'(cfg_q.cnt_x) * NXNY_W'(cfg_q.cnt_y);
    end
  end

  gcne_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .cfg_i        (cfg_q),
    .q_valid_o    (q_push_valid),
    .q_ready_i    (q_push_ready),
    .q_data_o     (q_push_data)
  );

  gcne_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(q_push_valid),
    .push_ready_o(q_push_ready),
    .push_data_i (q_push_data),
    .pop_valid_o (q_pop_valid),
    .pop_ready_i (q_pop_ready),
    .pop_data_o  (q_pop_data)
  );

  gcne_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .nxny_i       (nxny_q),
    .q_valid_i    (q_pop_valid),
    .q_ready_o    (q_pop_ready),
    .q_data_i     (q_pop_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

FILE: src/gcne_axis_div.sv
// One axis of the front end: restoring divider, one quotient bit per step, and grid check.
// Depends on gcne_pkg.
`timescale 1ns / 1ps

module gcne_axis_div (
  input  logic                            clk_i,
  input  logic                            load_i,
  input  logic                            step_i,
  input  logic [gcne_pkg::COORD_BITS-1:0] pos_i,
  input  logic [gcne_pkg::SIZE_W-1:0]     size_i,
  input  logic [gcne_pkg::COUNT_W-1:0]    count_i,
  output logic                            in_grid_o,
  output logic [gcne_pkg::AXIS_BITS-1:0]  cell_o
);
  import gcne_pkg::*;

  logic              neg_q, neg_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W:0]   trial;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    trial   = shifted - {1'b0, size_i};
    neg_d   = neg_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (load_i) begin
      neg_d = pos_i[COORD_BITS-1];
      quo_d = pos_i[DIV_W-1:0];
      rem_d = '0;
    end else if (step_i) begin
      if (!trial[SIZE_W]) begin
        rem_d = trial[SIZE_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[SIZE_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign in_grid_o = !neg_q && (CMP_W'(quo_q) < CMP_W'(count_i));
  assign cell_o    = AXIS_BITS'(quo_q);

endmodule

FILE: src/gcne_front.sv
// Front end: takes a position request, divides the three coordinates in parallel and
// classifies the cell as inside or outside the grid. Depends on gcne_pkg, gcne_axis_div.
`timescale 1ns / 1ps

module gcne_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [gcne_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  gcne_pkg::cfg_t                 cfg_i,
  output logic                           q_valid_o,
  input  logic                           q_ready_i,
  output gcne_pkg::cell_t                q_data_o
);
  import gcne_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e         state_q, state_d;
  logic                 hold_v_q, hold_v_d;
  logic [IN_RAW_W-1:0]  hold_q, hold_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 load, step;
  logic                 in_x, in_y, in_z;
  logic [AXIS_BITS-1:0] cell_x, cell_y, cell_z;

  assign s_axis_tready = !hold_v_q;

  always_comb begin
    state_d  = state_q;
    hold_v_d = hold_v_q;
    hold_d   = hold_q;
    cnt_d    = cnt_q;
    load     = 1'b0;
    step     = 1'b0;
    if (s_axis_tvalid && !hold_v_q) begin
      hold_v_d = 1'b1;
      hold_d   = s_axis_tdata[IN_RAW_W-1:0];
    end
    case (state_q)
      F_IDLE: begin
        if (hold_v_q) begin
          load     = 1'b1;
          hold_v_d = 1'b0;
          cnt_d    = '0;
          state_d  = F_DIV;
        end
      end
      F_DIV: begin
        step  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (q_ready_i) begin
          if (hold_v_q) begin
            load     = 1'b1;
            hold_v_d = 1'b0;
            cnt_d    = '0;
            state_d  = F_DIV;
          end else begin
            state_d = F_IDLE;
          end
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      hold_v_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      hold_v_q <= hold_v_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  gcne_axis_div u_div_x (
    .clk_i    (clk_i),
    .load_i   (load),
    .step_i   (step),
    .pos_i    (hold_q[COORD_BITS-1:0]),
    .size_i   (cfg_i.size_x),
    .count_i  (cfg_i.cnt_x),
    .in_grid_o(in_x),
    .cell_o   (cell_x)
  );

  gcne_axis_div u_div_y (
    .clk_i    (clk_i),
    .load_i   (load),
    .step_i   (step),
    .pos_i    (hold_q[2*COORD_BITS-1:COORD_BITS]),
    .size_i   (cfg_i.size_y),
    .count_i  (cfg_i.cnt_y),
    .in_grid_o(in_y),
    .cell_o   (cell_y)
  );

  gcne_axis_div u_div_z (
    .clk_i    (clk_i),
    .load_i   (load),
    .step_i   (step),
    .pos_i    (hold_q[3*COORD_BITS-1:2*COORD_BITS]),
    .size_i   (cfg_i.size_z),
    .count_i  (cfg_i.cnt_z),
    .in_grid_o(in_z),
    .cell_o   (cell_z)
  );

  always_comb begin
    q_valid_o        = (state_q == F_PUSH);
    q_data_o.outside = !(in_x && in_y && in_z);
    q_data_o.cx      = q_data_o.outside ? '0 : cell_x;
    q_data_o.cy      = q_data_o.outside ? '0 : cell_y;
    q_data_o.cz      = q_data_o.outside ? '0 : cell_z;
  end

endmodule

FILE: src/gcne_queue.sv
// Short register queue of classified cells between the front and the back end.
// Depends on gcne_pkg.
`timescale 1ns / 1ps

module gcne_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  gcne_pkg::cell_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output gcne_pkg::cell_t pop_data_o
);
  import gcne_pkg::*;

  cell_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/gcne_back.sv
// Back end: walks the existing cells of the 3x3x3 block around a queued cell, one per unstalled
// cycle, then forms the linear index in a product stage and an output register. Uses gcne_pkg.
`timescale 1ns / 1ps

module gcne_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gcne_pkg::cfg_t                  cfg_i,
  input  logic [gcne_pkg::NXNY_W-1:0]     nxny_i,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  gcne_pkg::cell_t                 q_data_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gcne_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import gcne_pkg::*;

  function automatic logic [AXIS_BITS-1:0] lo_of(input logic [AXIS_BITS-1:0] c);
    lo_of = (c == '0) ? '0 : c - 1'b1;
  endfunction

  function automatic logic [AXIS_BITS-1:0] hi_of(input logic [AXIS_BITS-1:0] c,
                                                  input logic [COUNT_W-1:0]   n);
    hi_of = ((COUNT_W'(c) + COUNT_W'(1)) == n) ? c : c + 1'b1;
  endfunction

  logic                 act_q, act_d;
  logic                 outs_q, outs_d;
  logic [AXIS_BITS-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [AXIS_BITS-1:0] xhi_q, xhi_d;
  logic [AXIS_BITS-1:0] ylo_q, ylo_d, yhi_q, yhi_d;
  logic [AXIS_BITS-1:0] zlo_q, zlo_d, zhi_q, zhi_d;
  logic [ORD_W-1:0]     ord_q, ord_d;

  logic                 s1_v_q;
  logic [NXNY_W-1:0]    s1_px_q;
  logic [IDX_W-1:0]     s1_pz_q;
  logic [AXIS_BITS-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic [ORD_W-1:0]     s1_ord_q;
  logic                 s1_outs_q, s1_last_q;

  logic                 out_v_q;
  logic [IDX_W-1:0]     out_idx_q;
  logic [AXIS_BITS-1:0] out_x_q, out_y_q, out_z_q;
  logic [ORD_W-1:0]     out_ord_q;
  logic                 out_outs_q, out_last_q;

  logic out_rdy, s1_en, emit, last_c, take;

  assign out_rdy   = !out_v_q || m_axis_tready;
  assign s1_en     = !s1_v_q || out_rdy;
  assign emit      = act_q && s1_en;
  assign last_c    = outs_q || ((x_q == xhi_q) && (y_q == yhi_q) && (z_q == zhi_q));
  assign q_ready_o = !act_q || (emit && last_c);
  assign take      = q_valid_i && q_ready_o;

  always_comb begin
    act_d  = act_q;
    outs_d = outs_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    xhi_d  = xhi_q;
    ylo_d  = ylo_q;
    yhi_d  = yhi_q;
    zlo_d  = zlo_q;
    zhi_d  = zhi_q;
    ord_d  = ord_q;
    if (take) begin
      act_d  = 1'b1;
      outs_d = q_data_i.outside;
      ylo_d  = lo_of(q_data_i.cy);
      zlo_d  = lo_of(q_data_i.cz);
      xhi_d  = hi_of(q_data_i.cx, cfg_i.cnt_x);
      yhi_d  = hi_of(q_data_i.cy, cfg_i.cnt_y);
      zhi_d  = hi_of(q_data_i.cz, cfg_i.cnt_z);
      x_d    = q_data_i.outside ? '0 : lo_of(q_data_i.cx);
      y_d    = q_data_i.outside ? '0 : lo_of(q_data_i.cy);
      z_d    = q_data_i.outside ? '0 : lo_of(q_data_i.cz);
      ord_d  = ORD_W'(1);
    end else if (emit) begin
      if (last_c) begin
        act_d = 1'b0;
      end else begin
        ord_d = ord_q + 1'b1;
        if (z_q != zhi_q) begin
          z_d = z_q + 1'b1;
        end else begin
          z_d = zlo_q;
          if (y_q != yhi_q) begin
            y_d = y_q + 1'b1;
          end else begin
            y_d = ylo_q;
            x_d = x_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      act_q <= act_d;
      if (s1_en) begin
        s1_v_q <= emit;
      end
      if (out_rdy) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    outs_q <= outs_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    xhi_q  <= xhi_d;
    ylo_q  <= ylo_d;
    yhi_q  <= yhi_d;
    zlo_q  <= zlo_d;
    zhi_q  <= zhi_d;
    ord_q  <= ord_d;
    if (s1_en) begin
      s1_px_q   <= NXNY_W'(x_q) * NXNY_W'(cfg_i.cnt_y);
      s1_pz_q   <= IDX_W'(z_q) * IDX_W'(nxny_i);
      s1_x_q    <= x_q;
      s1_y_q    <= y_q;
      s1_z_q    <= z_q;
      s1_ord_q  <= outs_q ? '0 : ord_q;
      s1_outs_q <= outs_q;
      s1_last_q <= last_c;
    end
    if (out_rdy) begin
      out_idx_q  <= s1_pz_q + IDX_W'(s1_px_q) + IDX_W'(s1_y_q);
      out_x_q    <= s1_x_q;
      out_y_q    <= s1_y_q;
      out_z_q    <= s1_z_q;
      out_ord_q  <= s1_ord_q;
      out_outs_q <= s1_outs_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_ord_q, out_z_q, out_y_q, out_x_q, out_idx_q});
  assign m_axis_tuser  = out_outs_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: bench/tb_grid_cell_neighbor_enumerator.sv
// Self-checking bench for grid_cell_neighbor_enumerator: drives positions and register writes,
// predicts every neighbor cell result and checks the output stream in order.
// Depends on gcne_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb_grid_cell_neighbor_enumerator;
  import gcne_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);
  localparam logic [SIZE_W-1:0]    SIZE_TOP     = '1;
  localparam longint               POS_SPAN     = longint'(1) << (COORD_BITS - 1);
  localparam int MAX_WAIT        = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASE_ITEMS     = 50;
  localparam int RANDOM_PHASES   = 8;
  localparam int TIMEOUT_NS      = 2_000_000;

  typedef enum int {IN_GRID, BEYOND_GRID, NEGATIVE, ANYWHERE} coord_kind_e;

  typedef struct packed {
    logic [IDX_W-1:0]     cell_index;
    logic [AXIS_BITS-1:0] cell_x;
    logic [AXIS_BITS-1:0] cell_y;
    logic [AXIS_BITS-1:0] cell_z;
    logic [ORD_W-1:0]     ordinal;
    logic                 outside;
    logic                 last;
  } neighbor_t;

  class neighbor_scoreboard;
    logic [SIZE_W-1:0]  cell_size[3];
    logic [COUNT_W-1:0] cell_count[3];
    neighbor_t          awaited_q[$];
    int mismatches, positions, neighbors, outsides;

    function new();
      foreach (cell_size[a]) begin
        cell_size[a]  = 1;
        cell_count[a] = 1;
      end
      mismatches = 0;
      positions  = 0;
      neighbors  = 0;
      outsides   = 0;
    endfunction

    function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SIZE_X:  cell_size[0]  = data[SIZE_W-1:0];
        REG_SIZE_Y:  cell_size[1]  = data[SIZE_W-1:0];
        REG_SIZE_Z:  cell_size[2]  = data[SIZE_W-1:0];
        REG_CELLS_X: cell_count[0] = data[COUNT_W-1:0];
        REG_CELLS_Y: cell_count[1] = data[COUNT_W-1:0];
        REG_CELLS_Z: cell_count[2] = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int axis_limit(int a);
      return (cell_count[a] > AXIS_MAX) ? int'(AXIS_MAX) : int'(cell_count[a]);
    endfunction

    function bit find_cell(int a, logic [COORD_BITS-1:0] raw, output int cell_no);
      int unsigned divisor;
      divisor = (cell_size[a] == 0) ? 1 : cell_size[a];
      cell_no = 0;
      if (raw[COORD_BITS-1]) return 0;
      cell_no = int'(raw[COORD_BITS-2:0] / divisor);
      return cell_no < axis_limit(a);
    endfunction

    function void note_request(logic [IN_DATA_W-1:0] data);
      logic [COORD_BITS-1:0] raw[3];
      int        home[3];
      int        lim[3];
      int        a, dx, dy, dz, x, y, z, ord;
      bit        found;
      longint    lin;
      neighbor_t r;
      neighbor_t batch[$];
      positions++;
      found = 1;
      for (a = 0; a < 3; a++) begin
        raw[a] = data[a*COORD_BITS +: COORD_BITS];
        lim[a] = axis_limit(a);
        if (!find_cell(a, raw[a], home[a])) found = 0;
      end
      if (!found) begin
        r = '0;
        r.outside = 1'b1;
        r.last = 1'b1;
        awaited_q = {awaited_q, r};
        outsides++;
        return;
      end
      ord = 0;
      for (dx = -1; dx <= 1; dx++) begin
        x = home[0] + dx;
        if (x < 0 || x >= lim[0]) continue;
        for (dy = -1; dy <= 1; dy++) begin
          y = home[1] + dy;
          if (y < 0 || y >= lim[1]) continue;
          for (dz = -1; dz <= 1; dz++) begin
            z = home[2] + dz;
            if (z < 0 || z >= lim[2]) continue;
            lin = longint'(z) * lim[0] * lim[1] + longint'(x) * lim[1] + y;
            ord++;
            r = '0;
            r.cell_index = lin[IDX_W-1:0];
            r.cell_x = x[AXIS_BITS-1:0];
            r.cell_y = y[AXIS_BITS-1:0];
            r.cell_z = z[AXIS_BITS-1:0];
            r.ordinal = ord[ORD_W-1:0];
            batch = {batch, r};
          end
        end
      end
      batch[batch.size()-1].last = 1'b1;
      awaited_q = {awaited_q, batch};
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task compare_field(string field, logic [IDX_W-1:0] got_v, logic [IDX_W-1:0] want_v);
      if (got_v !== want_v)
        report($sformatf("result %0d %s is %0d, expected %0d", neighbors, field, got_v, want_v));
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data, logic user, logic tl);
      neighbor_t want;
      neighbor_t got;
      neighbors++;
      got.cell_index = data[IDX_W-1:0];
      got.cell_x     = data[IDX_W +: AXIS_BITS];
      got.cell_y     = data[IDX_W+AXIS_BITS +: AXIS_BITS];
      got.cell_z     = data[IDX_W+2*AXIS_BITS +: AXIS_BITS];
      got.ordinal    = data[IDX_W+3*AXIS_BITS +: ORD_W];
      got.outside    = user;
      got.last       = tl;
      if (awaited_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing awaited: %h", neighbors, data));
        return;
      end
      want = awaited_q.pop_front();
      compare_field("cell_index", got.cell_index, want.cell_index);
      compare_field("cell_x", IDX_W'(got.cell_x), IDX_W'(want.cell_x));
      compare_field("cell_y", IDX_W'(got.cell_y), IDX_W'(want.cell_y));
      compare_field("cell_z", IDX_W'(got.cell_z), IDX_W'(want.cell_z));
      compare_field("ordinal", IDX_W'(got.ordinal), IDX_W'(want.ordinal));
      compare_field("outside", IDX_W'(got.outside), IDX_W'(want.outside));
      compare_field("last", IDX_W'(got.last), IDX_W'(want.last));
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  neighbor_scoreboard sb;
  logic [SIZE_W-1:0]  shape_size[3]  = '{1, 1, 1};
  logic [COUNT_W-1:0] shape_count[3] = '{1, 1, 1};
  int                 hold_off_req   = 0;
  bit                 steady         = 1'b0;
  int                 settings       = 1;

  grid_cell_neighbor_enumerator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.note_write(cfg_idx_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req > 0) begin
        stall = hold_off_req;
        hold_off_req = 0;
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_position(input logic [COORD_BITS-1:0] px, py, pz);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    do @(posedge clk_i); while (sb.awaited_q.size() != 0);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] count_word(input logic [COUNT_W-1:0] n);
    logic [CFG_DATA_W-1:0] w;
    w = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : '0;
    w[COUNT_W-1:0] = n;
    return w;
  endfunction

  task automatic load_grid(input logic [SIZE_W-1:0] sx, sy, sz,
                           input logic [COUNT_W-1:0] nx, ny, nz);
    put_reg(REG_SIZE_X, sx);
    put_reg(REG_SIZE_Y, sy);
    put_reg(REG_SIZE_Z, sz);
    put_reg(REG_CELLS_X, count_word(nx));
    put_reg(REG_CELLS_Y, count_word(ny));
    put_reg(REG_CELLS_Z, count_word(nz));
    cfg_we_i <= 1'b0;
    shape_size  = '{sx, sy, sz};
    shape_count = '{nx, ny, nz};
    settings++;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SIZE_W'(1);
      2: return SIZE_W'($urandom_range(2, 16));
      3: return SIZE_W'($urandom_range(17, 4096));
      4: return SIZE_W'($urandom);
      default: return SIZE_TOP;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return COUNT_W'(1);
      1: return COUNT_W'($urandom_range(2, 3));
      2: return COUNT_W'($urandom_range(4, 32));
      3: return COUNT_W'($urandom_range(33, 255));
      4: return AXIS_MAX;
      default: return COUNT_W'($urandom_range(257, 511));
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord(input int a, input coord_kind_e kind);
    longint s, n, span, c, base, room;
    s = (shape_size[a] == 0) ? 1 : shape_size[a];
    n = (shape_count[a] > AXIS_MAX) ? AXIS_MAX : shape_count[a];
    span = (n * s > POS_SPAN) ? POS_SPAN : n * s;
    case (kind)
      IN_GRID: begin
        if (n == 0) return COORD_BITS'($urandom_range(0, POS_SPAN - 1));
        case ($urandom_range(0, 4))
          0: c = 0;
          1: c = 1;
          2: c = n - 2;
          3: c = n - 1;
          default: c = $urandom_range(0, n - 1);
        endcase
        if (c < 0) c = 0;
        if (c * s >= span) c = (span - 1) / s;
        base = c * s;
        room = (s - 1 < span - 1 - base) ? s - 1 : span - 1 - base;
        return COORD_BITS'(base + $urandom_range(0, room));
      end
      BEYOND_GRID: begin
        if (span >= POS_SPAN || $urandom_range(0, 1)) return COORD_BITS'(span);
        return COORD_BITS'($urandom_range(span, POS_SPAN - 1));
      end
      NEGATIVE: begin
        case ($urandom_range(0, 3))
          0: return '1;
          1: return {1'b1, {(COORD_BITS-1){1'b0}}};
          default: return {1'b1, (COORD_BITS-1)'($urandom)};
        endcase
      end
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  task automatic random_position();
    logic [COORD_BITS-1:0] p[3];
    int fault_axis;
    int a;
    fault_axis = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : -1;
    for (a = 0; a < 3; a++)
      p[a] = pick_coord(a, (a == fault_axis) ?
                        coord_kind_e'($urandom_range(BEYOND_GRID, ANYWHERE)) : IN_GRID);
    send_position(p[0], p[1], p[2]);
  endtask

  initial begin : stimulus
    int ph, k;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A single-cell grid straight after reset.
    send_position(24'd0, 24'd0, 24'd0);
    send_position(24'd1, 24'd0, 24'd0);
    s_axis_tvalid <= 1'b0;
    drain();

    // Zero size on x, widest size on z, a count above range on z.
    load_grid('0, SIZE_W'(7), SIZE_TOP, AXIS_MAX, COUNT_W'(3), COUNT_W'(511));
    send_position(24'd0, 24'd0, 24'd0);
    send_position(24'd255, 24'd20, 24'h7FFFFF);
    send_position(24'd128, 24'd7, 24'd0);
    send_position(24'd256, 24'd0, 24'd0);
    send_position(24'd0, 24'd21, 24'd0);
    send_position(24'hFFFFFF, 24'd0, 24'd0);
    send_position(24'd0, 24'h800000, 24'd0);
    send_position(24'd0, 24'd0, 24'hFFFFFF);
    send_position(24'h7FFFFF, 24'd0, 24'd0);
    s_axis_tvalid <= 1'b0;
    drain();

    // Writes to indexes past the register list must leave the grid alone.
    put_reg(REG_SPARE_LO, '0);
    put_reg(REG_SPARE_HI, '0);
    cfg_we_i <= 1'b0;
    send_position(24'd128, 24'd7, 24'd0);
    s_axis_tvalid <= 1'b0;
    drain();

    load_grid(SIZE_W'(2), SIZE_W'(2), SIZE_W'(2), COUNT_W'(4), COUNT_W'(4), COUNT_W'(4));
    send_position(24'd3, 24'd3, 24'd3);
    send_position(24'd7, 24'd0, 24'd5);
    s_axis_tvalid <= 1'b0;
    drain();

    load_grid(SIZE_W'(1), SIZE_W'(1), SIZE_W'(1), AXIS_MAX, '0, AXIS_MAX);
    send_position(24'd5, 24'd5, 24'd5);
    send_position(24'd0, 24'd0, 24'd0);
    s_axis_tvalid <= 1'b0;
    drain();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: load_grid('0, SIZE_W'(1), '0, AXIS_MAX, COUNT_W'(511), AXIS_MAX);
        1: load_grid(SIZE_TOP, SIZE_TOP, SIZE_TOP, AXIS_MAX, AXIS_MAX, AXIS_MAX);
        2: load_grid(SIZE_W'(1), SIZE_W'(3), SIZE_W'(2), COUNT_W'(1), COUNT_W'(6), COUNT_W'(2));
        default: load_grid(pick_size(), pick_size(), pick_size(),
                           pick_count(), pick_count(), pick_count());
      endcase
      steady = (ph == 2 || ph == 5);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) begin
          s_axis_tvalid <= 1'b0;
          drain();
        end
        if (ph == 3 && k == 10) hold_off_req = HOLD_OFF_CYCLES;
        random_position();
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end

    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d neighbor results (%0d outside) from %0d positions over %0d settings.",
             sb.neighbors, sb.outsides, sb.positions, settings);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches found.", sb.mismatches);
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Run timed out with %0d results still awaited.", sb.awaited_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
